// ===== hw/rtl/buddy_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy allocator package
// Shared types for the buddy allocator sequencer.
// ----------------------------------------------------------------------------
package buddy_pkg;

   // item opcodes
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SIZE,
      ST_SCAN,
      ST_TAKE_RD,
      ST_TAKE_WAIT,
      ST_TAKE_WR,
      ST_SPLIT,
      ST_FREE_RD,
      ST_FREE_WAIT,
      ST_FREE_CHK,
      ST_BUD_WAIT,
      ST_BUD_CHK,
      ST_RM_WAIT,
      ST_RM_WR,
      ST_PUSH,
      ST_DONE
   } state_type;

endpackage

// ===== hw/rtl/buddy_allocator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy allocator core
// Binary buddy allocator over a pool of pages with LIFO free lists.
// ----------------------------------------------------------------------------
// An allocate finds the order that fits the size, scans the free lists upward,
// takes the first free block and splits it down to the order asked; a free checks
// the block's tag, merges with each free buddy one level up, then pushes the block.
// One item at a time: a new item is taken only once the core is idle and the last
// result has been taken.
// Reset: list heads return to one free block at the top order; a valid bit per
// page marks tag entries written since reset, so no clearing pass is needed.
module buddy_allocator_core
   import buddy_pkg::*;
#(
   parameter int PAGE_ORDER = 12,
   parameter int POOL_ORDER = 20
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_opcode,
   input  logic [23:0]           req_request_size,
   input  logic [POOL_ORDER-1:0] req_free_offset,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_success,
   output logic [POOL_ORDER-1:0] rsp_block_offset
);

   localparam int LW     = POOL_ORDER - PAGE_ORDER;      // page index width
   localparam int NPAGES = 1 << LW;
   localparam int NLEV   = LW + 1;
   localparam int TOP    = LW;
   localparam int VW     = $clog2(NLEV + 1);             // level width
   localparam int PW     = LW + 1;                       // page with NIL
   localparam logic [PW-1:0] NIL = PW'(NPAGES);
   localparam logic [VW-1:0] TAG_NONE = {VW{1'b1}};

   // Page memories: next/prev links, alloc tag, free tag
   logic [PW-1:0] nxt_mem [NPAGES];
   logic [PW-1:0] prv_mem [NPAGES];
   logic [VW-1:0] atag_mem [NPAGES];
   logic [VW-1:0] ftag_mem [NPAGES];
   // tags are valid only once written after reset
   logic [NPAGES-1:0] tag_vld_ff, tag_vld_in;

   logic [PW-1:0] head_ff [NLEV];
   logic [PW-1:0] head_in [NLEV];

   state_type state_ff, state_in;
   logic [VW-1:0] lv_ff, lv_in, req_ff, req_in;
   logic [LW-1:0] pg_ff, pg_in, bud_ff, bud_in;
   logic          op_ff, op_in;
   logic [23:0]   size_ff, size_in;
   logic [5:0]    ord_ff, ord_in;
   logic          rv_ff, rv_in, rs_ff, rs_in;
   logic [POOL_ORDER-1:0] ro_ff, ro_in;

   // memory port controls (one read and one write per memory per cycle)
   logic [LW-1:0] ra;
   logic [PW-1:0] rd_nxt, rd_prv;
   logic [VW-1:0] rd_atag, rd_ftag;
   logic          rd_tv;
   logic          wn_en, wp_en, wa_en, wf_en;
   logic [LW-1:0] wn_a, wp_a, wa_a, wf_a;
   logic [PW-1:0] wn_d, wp_d;
   logic [VW-1:0] wa_d, wf_d;
   // second prev write for list pushes is done in a following cycle
   logic [PW-1:0] n_save_ff, n_save_in, v_save_ff, v_save_in;
   logic          pend_ff, pend_in;

   always_ff @(posedge clock) begin
      rd_nxt  <= nxt_mem[ra];
      rd_prv  <= prv_mem[ra];
      rd_atag <= atag_mem[ra];
      rd_ftag <= ftag_mem[ra];
      rd_tv   <= tag_vld_ff[ra];
      if (wn_en) nxt_mem[wn_a] <= wn_d;
      if (wp_en) prv_mem[wp_a] <= wp_d;
      if (wa_en) atag_mem[wa_a] <= wa_d;
      if (wf_en) ftag_mem[wf_a] <= wf_d;
   end

   logic [VW-1:0] atag_v, ftag_v;
   logic [PW-1:0] nxt_v;
   assign atag_v = rd_tv ? rd_atag : TAG_NONE;
   assign ftag_v = rd_tv ? rd_ftag : ((bud_ff == '0) ? VW'(TOP) : TAG_NONE);
   // page 0 is the only page taken before it is written: its next link is NIL
   assign nxt_v  = rd_tv ? rd_nxt : NIL;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rv_ff    <= 1'b0;
         tag_vld_ff <= '0;
         pend_ff  <= 1'b0;
         for (int i = 0; i < NLEV; i++) head_ff[i] <= (i == TOP) ? '0 : NIL;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
         tag_vld_ff <= tag_vld_in;
         pend_ff  <= pend_in;
         for (int i = 0; i < NLEV; i++) head_ff[i] <= head_in[i];
      end
      lv_ff <= lv_in; req_ff <= req_in; pg_ff <= pg_in; bud_ff <= bud_in;
      op_ff <= op_in; size_ff <= size_in; ord_ff <= ord_in;
      rs_ff <= rs_in; ro_ff <= ro_in;
      n_save_ff <= n_save_in; v_save_ff <= v_save_in;
   end

   // page tag valid bit: page 0 reads as free at top until written
   function automatic logic [NPAGES-1:0] setv(logic [NPAGES-1:0] v,
                                               logic [LW-1:0] a);
      logic [NPAGES-1:0] r;
      r = v;
      r[a] = 1'b1;
      return r;
   endfunction

   logic [LW-1:0] half;

   always_comb begin
      state_in = state_ff;
      lv_in = lv_ff; req_in = req_ff; pg_in = pg_ff; bud_in = bud_ff;
      op_in = op_ff; size_in = size_ff; ord_in = ord_ff;
      rv_in = rv_ff; rs_in = rs_ff; ro_in = ro_ff;
      n_save_in = n_save_ff; v_save_in = v_save_ff;
      pend_in = 1'b0;
      tag_vld_in = tag_vld_ff;
      for (int i = 0; i < NLEV; i++) head_in[i] = head_ff[i];
      ra = pg_ff;
      wn_en = 1'b0; wp_en = 1'b0; wa_en = 1'b0; wf_en = 1'b0;
      wn_a = pg_ff; wp_a = pg_ff; wa_a = pg_ff; wf_a = pg_ff;
      wn_d = NIL; wp_d = NIL; wa_d = TAG_NONE; wf_d = TAG_NONE;
      half = '0;
      req_stall = (state_ff != ST_IDLE) || rv_ff;

      // deferred prev-link fix of a pushed list's old head
      if (pend_ff) begin
         wp_en = 1'b1;
         wp_a  = n_save_ff[LW-1:0];
         wp_d  = v_save_ff;
      end

      if (rv_ff && !rsp_stall) rv_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && !rv_ff) begin
               op_in = req_opcode;
               size_in = req_request_size;
               ord_in = '0;
               pg_in = req_free_offset[POOL_ORDER-1:PAGE_ORDER];
               state_in = (req_opcode == OP_FREE) ? ST_FREE_RD : ST_SIZE;
            end
         end
         // one order step per cycle until 2^ord >= size
         ST_SIZE: begin
            if (size_ff == '0) begin
               rs_in = 1'b0; state_in = ST_DONE;
            end else if ((25'd1 << ord_ff) >= {1'b0, size_ff}) begin
               if (ord_ff > 6'(POOL_ORDER)) begin
                  rs_in = 1'b0; state_in = ST_DONE;
               end else begin
                  req_in = (ord_ff < 6'(PAGE_ORDER)) ? '0
                                                      : VW'(ord_ff - 6'(PAGE_ORDER));
                  lv_in = (ord_ff < 6'(PAGE_ORDER)) ? '0
                                                     : VW'(ord_ff - 6'(PAGE_ORDER));
                  state_in = ST_SCAN;
               end
            end else begin
               ord_in = ord_ff + 6'd1;
            end
         end
         ST_SCAN: begin
            if (int'(lv_ff) >= NLEV) begin
               rs_in = 1'b0; state_in = ST_DONE;
            end else if (head_ff[lv_ff] != NIL) begin
               pg_in = head_ff[lv_ff][LW-1:0];
               state_in = ST_TAKE_RD;
            end else begin
               lv_in = lv_ff + VW'(1);
            end
         end
         ST_TAKE_RD: begin
            ra = pg_ff; state_in = ST_TAKE_WAIT;
         end
         ST_TAKE_WAIT: state_in = ST_TAKE_WR;
         // the head has no prev: unlink from the list head
         ST_TAKE_WR: begin
            head_in[lv_ff] = nxt_v;
            if (nxt_v != NIL) begin
               wp_en = 1'b1; wp_a = nxt_v[LW-1:0]; wp_d = NIL;
            end
            wf_en = 1'b1; wf_a = pg_ff; wf_d = TAG_NONE;
            wa_en = 1'b1; wa_a = pg_ff; wa_d = atag_v;
            tag_vld_in = setv(tag_vld_ff, pg_ff);
            state_in = ST_SPLIT;
         end
         // push one right half per cycle; old head prev fixed next cycle
         ST_SPLIT: begin
            if (lv_ff > req_ff) begin
               half = pg_ff | (LW'(1) << (lv_ff - VW'(1)));
               wn_en = 1'b1; wn_a = half; wn_d = head_ff[lv_ff - VW'(1)];
               wf_en = 1'b1; wf_a = half; wf_d = lv_ff - VW'(1);
               wa_en = 1'b1; wa_a = half; wa_d = TAG_NONE;
               tag_vld_in = setv(tag_vld_ff, half);
               // prev of the new head written when pend is idle
               if (!pend_ff) begin
                  wp_en = 1'b1; wp_a = half; wp_d = NIL;
               end
               if (head_ff[lv_ff - VW'(1)] != NIL) begin
                  pend_in = 1'b1;
                  n_save_in = head_ff[lv_ff - VW'(1)];
                  v_save_in = {1'b0, half};
               end
               head_in[lv_ff - VW'(1)] = {1'b0, half};
               lv_in = lv_ff - VW'(1);
               // pend slot busy: redo prev of this page next cycle is not
               // needed since a split level list is always empty here
            end else begin
               wa_en = 1'b1; wa_a = pg_ff; wa_d = req_ff;
               rs_in = 1'b1;
               ro_in = POOL_ORDER'({pg_ff, {PAGE_ORDER{1'b0}}});
               state_in = ST_DONE;
            end
         end
         ST_FREE_RD: begin
            ra = pg_ff; state_in = ST_FREE_WAIT;
         end
         ST_FREE_WAIT: state_in = ST_FREE_CHK;
         ST_FREE_CHK: begin
            if (int'(atag_v) >= NLEV) begin
               rs_in = 1'b0; state_in = ST_DONE;
            end else begin
               wa_en = 1'b1; wa_a = pg_ff; wa_d = TAG_NONE;
               wf_en = 1'b1; wf_a = pg_ff; wf_d = ftag_v;
               tag_vld_in = setv(tag_vld_ff, pg_ff);
               lv_in = atag_v;
               bud_in = pg_ff ^ (LW'(1) << atag_v);
               state_in = (int'(atag_v) < TOP) ? ST_BUD_WAIT : ST_PUSH;
            end
         end
         ST_BUD_WAIT: begin
            ra = bud_ff; state_in = ST_BUD_CHK;
         end
         // hold the buddy address so its entry is read again after any write
         ST_BUD_CHK: begin
            ra = bud_ff; state_in = ST_RM_WAIT;
         end
         ST_RM_WAIT: begin
            if (ftag_v != lv_ff) state_in = ST_PUSH;
            else begin
               n_save_in = rd_nxt; v_save_in = rd_prv;
               state_in = ST_RM_WR;
            end
         end
         // unlink the buddy from its list and merge one level up
         ST_RM_WR: begin
            if (v_save_ff != NIL) begin
               wn_en = 1'b1; wn_a = v_save_ff[LW-1:0]; wn_d = n_save_ff;
            end else begin
               head_in[lv_ff] = n_save_ff;
            end
            if (n_save_ff != NIL) begin
               wp_en = 1'b1; wp_a = n_save_ff[LW-1:0]; wp_d = v_save_ff;
            end
            // a free buddy never starts an allocated block
            wf_en = 1'b1; wf_a = bud_ff; wf_d = TAG_NONE;
            wa_en = 1'b1; wa_a = bud_ff; wa_d = TAG_NONE;
            tag_vld_in = setv(tag_vld_ff, bud_ff);
            pg_in = pg_ff & ~(LW'(1) << lv_ff);
            lv_in = lv_ff + VW'(1);
            bud_in = (pg_ff & ~(LW'(1) << lv_ff)) ^ (LW'(1) << (lv_ff + VW'(1)));
            state_in = (int'(lv_ff) + 1 < TOP) ? ST_BUD_WAIT : ST_PUSH;
         end
         ST_PUSH: begin
            wn_en = 1'b1; wn_a = pg_ff; wn_d = head_ff[lv_ff];
            wp_en = 1'b1; wp_a = pg_ff; wp_d = NIL;
            wf_en = 1'b1; wf_a = pg_ff; wf_d = lv_ff;
            wa_en = 1'b1; wa_a = pg_ff; wa_d = TAG_NONE;
            tag_vld_in = setv(tag_vld_ff, pg_ff);
            if (head_ff[lv_ff] != NIL) begin
               pend_in = 1'b1;
               n_save_in = head_ff[lv_ff];
               v_save_in = {1'b0, pg_ff};
            end
            head_in[lv_ff] = {1'b0, pg_ff};
            rs_in = 1'b1; ro_in = '0;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (op_ff == OP_ALLOC && !rs_ff) ro_in = '0;
            if (op_ff == OP_FREE) ro_in = '0;
            rv_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = rv_ff;
   assign rsp_success = rs_ff;
   assign rsp_block_offset = ro_ff;

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      rv_ff |-> req_stall) else $error("item taken while result pending");
   a_idle_out: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && !rsp_success) |-> (rsp_block_offset == '0))
      else $error("failed item carries an offset");
   a_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |=> rv_ff) else $error("result lost");

endmodule

// ===== dv/buddy_allocator_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy allocator core testbench
// Drives allocate and free items into the core and checks every result against
// a local model of the buddy free lists and page tags. A directed opening
// covers size limits, exhaustion, bad frees and full merges; a random tail
// mixes allocations, frees of live blocks and stray frees under random stalls.
// ----------------------------------------------------------------------------
module buddy_allocator_core_tb
   import buddy_pkg::*;
();

   localparam int PAGE_ORD   = 12;
   localparam int POOL_ORD   = 20;
   localparam int NUM_PAGES  = 1 << (POOL_ORD - PAGE_ORD);
   localparam int NUM_LEVELS = POOL_ORD - PAGE_ORD + 1;
   localparam int TOP_LVL    = POOL_ORD - PAGE_ORD;
   localparam int NIL        = NUM_PAGES;
   localparam logic [3:0] TAG_NONE = 4'hF;
   localparam int CYCLE_LIMIT = 400000;
   localparam int QUIET_START = 3000;
   localparam int QUIET_END   = 6000;

   typedef struct {
      logic                op;
      logic [23:0]         size;
      logic [POOL_ORD-1:0] offset;
      bit                  drain;
      logic                ok;
      logic [POOL_ORD-1:0] blk;
   } alloc_item_type;

   typedef struct {
      logic                ok;
      logic [POOL_ORD-1:0] blk;
   } alloc_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_opcode = OP_ALLOC;
   logic [23:0]         req_request_size = '0;
   logic [POOL_ORD-1:0] req_free_offset = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic                rsp_success;
   logic [POOL_ORD-1:0] rsp_block_offset;

   buddy_allocator_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_opcode(req_opcode),
      .req_request_size(req_request_size), .req_free_offset(req_free_offset),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_success(rsp_success),
      .rsp_block_offset(rsp_block_offset)
   );

   always #4 clock = ~clock;

   // Local copy of the allocator state, kept at page granularity.
   int         head_page [NUM_LEVELS];
   int         next_page [NUM_PAGES];
   int         prev_page [NUM_PAGES];
   logic [3:0] used_tag  [NUM_PAGES];
   logic [3:0] avail_tag [NUM_PAGES];

   alloc_item_type   pending_q[$];
   alloc_result_type result_q[$];
   logic [POOL_ORD-1:0] live_blocks[$];
   alloc_item_type   cur;
   bit            taken = 0;
   int            errors = 0;
   int            cycle = 0;

   // Link a page at the head of the free list of its level.
   function void list_push(int lv, int p);
      int h;
      h = head_page[lv];
      next_page[p] = h;
      prev_page[p] = NIL;
      if (h < NUM_PAGES) prev_page[h] = p;
      head_page[lv] = p;
      avail_tag[p] = lv[3:0];
   endfunction

   // Unlink a page from anywhere in its free list.
   function void list_unlink(int lv, int p);
      int n, v;
      n = next_page[p];
      v = prev_page[p];
      if (v < NUM_PAGES) next_page[v] = n;
      else head_page[lv] = n;
      if (n < NUM_PAGES) prev_page[n] = v;
      avail_tag[p] = TAG_NONE;
   endfunction

   // Apply one item to the local state and return what the core should answer.
   function automatic void predict_alloc(ref alloc_item_type it);
      int ord, req, lv, p, b;
      it.ok = 1'b0;
      it.blk = '0;
      if (it.op == OP_ALLOC) begin
         if (it.size == 0) return;
         ord = 0;
         while (ord < 40 && (64'd1 << ord) < it.size) ord++;
         if (ord < PAGE_ORD) ord = PAGE_ORD;
         if (ord > POOL_ORD) return;
         req = ord - PAGE_ORD;
         lv = req;
         while (lv < NUM_LEVELS && head_page[lv] >= NUM_PAGES) lv++;
         if (lv >= NUM_LEVELS) return;
         p = head_page[lv];
         list_unlink(lv, p);
         while (lv > req) begin
            lv--;
            list_push(lv, p + (1 << lv));
         end
         used_tag[p] = req[3:0];
         it.ok = 1'b1;
         it.blk = POOL_ORD'(p << PAGE_ORD);
      end else begin
         p = int'(it.offset >> PAGE_ORD);
         if (used_tag[p] == TAG_NONE) return;
         lv = used_tag[p];
         used_tag[p] = TAG_NONE;
         while (lv < TOP_LVL) begin
            b = p ^ (1 << lv);
            if (avail_tag[b] != lv[3:0]) break;
            list_unlink(lv, b);
            p = p & ~(1 << lv);
            lv++;
         end
         list_push(lv, p);
         it.ok = 1'b1;
      end
   endfunction

   // Predict an item, track live blocks, and queue it for the driver.
   function void queue_item(logic op, logic [23:0] size, logic [POOL_ORD-1:0] off,
                            bit drain);
      alloc_item_type it;
      it.op = op;
      it.size = size;
      it.offset = off;
      it.drain = drain;
      predict_alloc(it);
      if (op == OP_ALLOC && it.ok) live_blocks.push_back(it.blk);
      pending_q.push_back(it);
   endfunction

   // Driver: present items at the falling edge, hold while stalled.
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || taken) begin
            taken = 0;
            if (pending_q.size() != 0 &&
                !(pending_q[0].drain && result_q.size() != 0) &&
                ((cycle >= QUIET_START && cycle < QUIET_END) ||
                 $urandom_range(0, 99) >= 28)) begin
               cur = pending_q.pop_front();
               req_valid <= 1'b1;
               req_opcode <= cur.op;
               req_request_size <= cur.size;
               req_free_offset <= cur.offset;
            end else begin
               req_valid <= 1'b0;
            end
         end
         if (cycle >= QUIET_START && cycle < QUIET_END) rsp_stall <= 1'b0;
         else rsp_stall <= ($urandom_range(0, 99) < 28);
      end
   end

   // Monitor: record accepted items and check results at the rising edge.
   always @(posedge clock) begin
      alloc_result_type want;
      cycle <= cycle + 1;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            taken = 1;
            want.ok = cur.ok;
            want.blk = cur.blk;
            result_q.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            if (result_q.size() == 0) begin
               $display("%0t: unexpected result success=%0b offset=%h",
                        $time, rsp_success, rsp_block_offset);
               errors++;
            end else begin
               want = result_q.pop_front();
               if (rsp_success !== want.ok) begin
                  $display("%0t: success expected %0b actual %0b",
                           $time, want.ok, rsp_success);
                  errors++;
               end
               if (rsp_block_offset !== want.blk) begin
                  $display("%0t: block_offset expected %h actual %h",
                           $time, want.blk, rsp_block_offset);
                  errors++;
               end
            end
         end
      end
      if (cycle > CYCLE_LIMIT) begin
         $display("buddy_allocator_core: mismatch");
         $finish;
      end
   end

   initial begin
      int r, o, k;
      logic [POOL_ORD-1:0] off;

      for (int i = 0; i < NUM_LEVELS; i++) head_page[i] = NIL;
      for (int i = 0; i < NUM_PAGES; i++) begin
         next_page[i] = NIL;
         prev_page[i] = NIL;
         used_tag[i] = TAG_NONE;
         avail_tag[i] = TAG_NONE;
      end
      list_push(TOP_LVL, 0);

      // Directed opening: size limits, exhaustion, bad frees, full merge.
      queue_item(OP_ALLOC, 24'd0, '0, 0);          // zero size fails
      queue_item(OP_ALLOC, 24'h100000, '0, 0);     // whole pool
      queue_item(OP_ALLOC, 24'd1, '0, 0);          // nothing free
      queue_item(OP_FREE, 24'hFFFFFF, 20'h00000, 1);
      live_blocks.delete();
      queue_item(OP_FREE, 24'd0, 20'h00000, 0);    // double free
      queue_item(OP_ALLOC, 24'hFFFFFF, '0, 0);     // above pool
      queue_item(OP_ALLOC, 24'h100001, '0, 0);     // just above pool
      queue_item(OP_ALLOC, 24'd1, 20'hFFFFF, 0);
      queue_item(OP_ALLOC, 24'd4096, '0, 0);
      queue_item(OP_ALLOC, 24'd4097, '0, 0);
      queue_item(OP_ALLOC, 24'h80000, '0, 0);
      queue_item(OP_FREE, '0, 20'h55000, 0);       // never allocated
      queue_item(OP_FREE, '0, 20'h03000, 0);       // inside a block, not its start
      queue_item(OP_FREE, '0, 20'hFFFFF, 0);
      queue_item(OP_FREE, '0, live_blocks[1] | 20'hABC, 0);  // offset inside page
      live_blocks.delete(1);
      while (live_blocks.size() != 0) queue_item(OP_FREE, '0, live_blocks.pop_front(), 0);
      queue_item(OP_ALLOC, 24'h100000, '0, 1);     // full merge restored the pool
      queue_item(OP_FREE, '0, live_blocks.pop_front(), 0);

      // Random tail: mostly valid alloc/free traffic, some noise.
      for (int n = 0; n < 630; n++) begin
         r = $urandom_range(0, 99);
         if (r < 35 && live_blocks.size() != 0) begin
            k = $urandom_range(0, live_blocks.size() - 1);
            off = live_blocks[k];
            live_blocks.delete(k);
            if ($urandom_range(0, 3) == 0) off = off | 20'($urandom_range(0, 4095));
            queue_item(OP_FREE, 24'($urandom), off, (n % 150) == 149);
         end else if (r < 45) begin
            queue_item(OP_FREE, 24'($urandom), 20'($urandom), (n % 150) == 149);
         end else begin
            k = $urandom_range(0, 99);
            if (k < 4) queue_item(OP_ALLOC, 24'd0, 20'($urandom), (n % 150) == 149);
            else if (k < 10) queue_item(OP_ALLOC, 24'($urandom), 20'($urandom),
                                        (n % 150) == 149);
            else begin
               o = (k < 20) ? $urandom_range(15, 20) : $urandom_range(0, 15);
               queue_item(OP_ALLOC,
                          (o == 0) ? 24'd1 :
                             24'($urandom_range((1 << (o - 1)) + 1, 1 << o)),
                          20'($urandom), (n % 150) == 149);
            end
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Drain: all items in, all results out, then a settling margin.
      wait (pending_q.size() == 0 && !req_valid && result_q.size() == 0);
      repeat (100) @(posedge clock);
      if (errors == 0 && result_q.size() == 0) begin
         $display("buddy_allocator_core: match");
      end else begin
         $display("buddy_allocator_core: mismatch");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/buddy_pkg.sv
hw/rtl/buddy_allocator_core.sv
dv/buddy_allocator_core_tb.sv
